FILE: rtl/orbit_camera_eye_position_assert.svh
// Assertion macros for the orbit camera eye position block.
// Included by the top-level module, which carries the concurrent checks.
`ifndef ORBIT_CAMERA_EYE_POSITION_ASSERT_SVH
`define ORBIT_CAMERA_EYE_POSITION_ASSERT_SVH
`ifndef NO_ASSERTIONS
// implication checked on every clock edge outside reset
`define OCE_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define OCE_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define OCE_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define OCE_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

FILE: rtl/oce_pkg.sv
// Package for the orbit camera eye position block: widths, register
// indexes, CORDIC constants and the sequencer state type. No dependencies.
package oce_pkg;

    localparam int CORDIC_STEPS_DEF = 16;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_START_RADIUS = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_START_INCL   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_START_AZIM   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ZOOM_STEP    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_RADIUS   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_TURN_GAIN    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_INCL     = 3'd6;

    localparam logic [34:0] CORDIC_GAIN = 35'h026DD3B6A;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ANGLE,
        ST_LOAD,
        ST_CORDIC,
        ST_MUL_GO,
        ST_MUL,
        ST_DONE
    } t_state;

    // control from the sequencer to the CORDIC unit
    typedef struct packed {
        logic start;
        logic step;
    } t_cordic_ctl;

    // atan(2^-i) in 2^-32 turn units
    function automatic logic [31:0] atan_lut(input logic [4:0] idx);
        logic [31:0] v;
        case (idx)
            5'd0:  v = 32'h20000000;
            5'd1:  v = 32'h12E4051E;
            5'd2:  v = 32'h09FB385B;
            5'd3:  v = 32'h051111D4;
            5'd4:  v = 32'h028B0D43;
            5'd5:  v = 32'h0145D7E1;
            5'd6:  v = 32'h00A2F61E;
            5'd7:  v = 32'h00517C55;
            5'd8:  v = 32'h0028BE53;
            5'd9:  v = 32'h00145F2F;
            5'd10: v = 32'h000A2F98;
            5'd11: v = 32'h000517CC;
            5'd12: v = 32'h00028BE6;
            5'd13: v = 32'h000145F3;
            5'd14: v = 32'h0000A2FA;
            5'd15: v = 32'h0000517D;
            5'd16: v = 32'h000028BE;
            5'd17: v = 32'h0000145F;
            5'd18: v = 32'h00000A30;
            5'd19: v = 32'h00000518;
            5'd20: v = 32'h0000028C;
            5'd21: v = 32'h00000146;
            5'd22: v = 32'h000000A3;
            5'd23: v = 32'h00000051;
            default: v = 32'h00000000;
        endcase
        return v;
    endfunction

endpackage

FILE: rtl/oce_cordic.sv
// Dual CORDIC rotator: sine and cosine of two 16-bit angles, one
// micro-rotation per step command. Depends on oce_pkg.
module oce_cordic (
    input  logic                i_clk,
    input  oce_pkg::t_cordic_ctl i_ctl,
    input  logic [4:0]          i_iter,
    input  logic [15:0]         i_ang_a,
    input  logic [15:0]         i_ang_b,
    output logic signed [17:0]  o_cos_a,
    output logic signed [17:0]  o_sin_a,
    output logic signed [17:0]  o_cos_b,
    output logic signed [17:0]  o_sin_b
);

    logic signed [34:0] r_xa, r_ya, r_xb, r_yb, n_xa, n_ya, n_xb, n_yb;
    logic signed [32:0] r_za, r_zb, n_za, n_zb;
    logic r_nega, r_negb, n_nega, n_negb;
    logic [31:0] w_at;
    logic [15:0] w_fa, w_fb;

    assign w_at = oce_pkg::atan_lut(i_iter);
    assign w_fa = i_ang_a + 16'h4000;
    assign w_fb = i_ang_b + 16'h4000;

    // load folded angles, then rotate once per step
    always_comb begin
        n_xa = r_xa; n_ya = r_ya; n_za = r_za; n_nega = r_nega;
        n_xb = r_xb; n_yb = r_yb; n_zb = r_zb; n_negb = r_negb;
        if (i_ctl.start) begin
            n_nega = w_fa[15];
            n_negb = w_fb[15];
            n_xa = oce_pkg::CORDIC_GAIN; n_ya = '0;
            n_xb = oce_pkg::CORDIC_GAIN; n_yb = '0;
            n_za = 33'(signed'({(w_fa[15] ? ~i_ang_a[15] : i_ang_a[15]),
                   i_ang_a[14:0], 16'h0000}));
            n_zb = 33'(signed'({(w_fb[15] ? ~i_ang_b[15] : i_ang_b[15]),
                   i_ang_b[14:0], 16'h0000}));
        end else if (i_ctl.step) begin
            if (!r_za[32]) begin
                n_xa = r_xa - (r_ya >>> i_iter);
                n_ya = r_ya + (r_xa >>> i_iter);
                n_za = r_za - $signed({1'b0, w_at});
            end else begin
                n_xa = r_xa + (r_ya >>> i_iter);
                n_ya = r_ya - (r_xa >>> i_iter);
                n_za = r_za + $signed({1'b0, w_at});
            end
            if (!r_zb[32]) begin
                n_xb = r_xb - (r_yb >>> i_iter);
                n_yb = r_yb + (r_xb >>> i_iter);
                n_zb = r_zb - $signed({1'b0, w_at});
            end else begin
                n_xb = r_xb + (r_yb >>> i_iter);
                n_yb = r_yb - (r_xb >>> i_iter);
                n_zb = r_zb + $signed({1'b0, w_at});
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_xa <= n_xa; r_ya <= n_ya; r_za <= n_za; r_nega <= n_nega;
        r_xb <= n_xb; r_yb <= n_yb; r_zb <= n_zb; r_negb <= n_negb;
    end

    // negate on fold, round to Q16
    function automatic logic signed [17:0] rnd(input logic signed [34:0] v, input logic ng);
        logic signed [35:0] t;
        logic signed [35:0] s;
        t = ng ? -36'(v) : 36'(v);
        s = (t + 36'sd8192) >>> 14;
        return s[17:0];
    endfunction

    assign o_cos_a = rnd(r_xa, r_nega);
    assign o_sin_a = rnd(r_ya, r_nega);
    assign o_cos_b = rnd(r_xb, r_negb);
    assign o_sin_b = rnd(r_yb, r_negb);

endmodule

FILE: rtl/oce_serial_mul.sv
// Bit-serial signed multiplier: shift-and-add, one multiplier bit per
// cycle. No package dependencies.
module oce_serial_mul #(
    parameter int AW = 34,
    parameter int BW = 18
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic signed [AW-1:0]    i_a,
    input  logic signed [BW-1:0]    i_b,
    output logic                    o_done,
    output logic signed [AW+BW-1:0] o_p
);

    localparam int CW = $clog2(BW + 1);

    logic signed [AW+BW-1:0] r_acc, n_acc, r_a, n_a;
    logic [BW-1:0] r_b, n_b;
    logic [CW-1:0] r_cnt, n_cnt;
    logic r_busy, n_busy;
    logic r_done;

    // add the shifted multiplicand per bit, subtract at the sign bit
    always_comb begin
        n_acc = r_acc; n_a = r_a; n_b = r_b; n_cnt = r_cnt; n_busy = r_busy;
        if (i_start) begin
            n_acc = '0;
            n_a = (AW + BW)'(i_a);
            n_b = i_b;
            n_cnt = '0;
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (r_b[0]) begin
                if (r_cnt == CW'(BW - 1)) n_acc = r_acc - r_a;
                else n_acc = r_acc + r_a;
            end
            n_a = r_a <<< 1;
            n_b = r_b >> 1;
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == CW'(BW - 1)) n_busy = 1'b0;
        end
    end

    // pulse done once the last bit has been added in
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt <= '0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_cnt <= n_cnt;
            r_done <= r_busy && (r_cnt == CW'(BW - 1));
        end
        r_acc <= n_acc; r_a <= n_a; r_b <= n_b;
    end

    assign o_done = r_done;
    assign o_p = r_acc;

endmodule

FILE: rtl/orbit_camera_eye_position.sv
// Top level of the orbit camera eye position block: state update,
// sequencer, CORDIC unit and serial multipliers. Depends on oce_pkg.
//
//   channel   dir  handshake             payload
//   in        in   i_valid / o_ready     wheel_delta, pointer_dx/dy, left_button
//   out       out  o_valid / i_ready     eye_x, eye_y, eye_z
//   cfg       in   i_cfg_we              i_cfg_idx, i_cfg_data
//
// One word passes from accept through angle update, CORDIC load, the CORDIC
// loop, two rounds on the 18-bit serial multipliers and a result state,
// then returns to idle before the next word is accepted.
// Reset (synchronous, active low) loads defaults and the start state.
// A result waits in the output register; a new word is taken meanwhile, and
// the next result stalls in its last cycle until the waiting one is taken.
// Start registers act on the state only at the next reset.
module orbit_camera_eye_position #(
    parameter int CORDIC_STEPS = oce_pkg::CORDIC_STEPS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_ready,
    input  logic signed [15:0]               i_wheel_delta,
    input  logic signed [15:0]               i_pointer_dx,
    input  logic signed [15:0]               i_pointer_dy,
    input  logic                             i_left_button,
    output logic                             o_valid,
    input  logic                             i_ready,
    output logic signed [16:0]               o_eye_x,
    output logic signed [16:0]               o_eye_y,
    output logic signed [16:0]               o_eye_z,
    input  logic                             i_cfg_we,
    input  logic [oce_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [oce_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

`include "orbit_camera_eye_position_assert.svh"

    // configuration registers
    logic [15:0] r_start_radius, r_start_azim, r_zoom_step, r_min_radius, r_turn_gain;
    logic signed [14:0] r_start_incl;
    logic [13:0] r_max_incl;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_radius <= 16'd1280;
            r_start_incl <= '0;
            r_start_azim <= '0;
            r_zoom_step <= 16'd26;
            r_min_radius <= 16'd26;
            r_turn_gain <= 16'd26701;
            r_max_incl <= 14'd15341;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                oce_pkg::REG_START_RADIUS: r_start_radius <= i_cfg_data;
                oce_pkg::REG_START_INCL:   r_start_incl <= i_cfg_data[14:0];
                oce_pkg::REG_START_AZIM:   r_start_azim <= i_cfg_data;
                oce_pkg::REG_ZOOM_STEP:    r_zoom_step <= i_cfg_data;
                oce_pkg::REG_MIN_RADIUS:   r_min_radius <= i_cfg_data;
                oce_pkg::REG_TURN_GAIN:    r_turn_gain <= i_cfg_data;
                oce_pkg::REG_MAX_INCL:     r_max_incl <= i_cfg_data[13:0];
                default: ;
            endcase
        end
    end

    oce_pkg::t_state r_state, n_state;
    logic [15:0] r_radius, n_radius;
    logic signed [15:0] r_incl, n_incl;
    logic [15:0] r_azim, n_azim;
    logic signed [15:0] r_dx, r_dy;
    logic r_held;
    logic [4:0] r_iter;
    logic r_phase;
    logic r_ovalid;
    logic signed [16:0] r_ex, r_ey, r_ez, r_ey_q;
    oce_pkg::t_cordic_ctl w_ctl;
    logic w_m_start;
    logic w_mdone;
    logic signed [17:0] w_ci, w_si, w_ca, w_sa;
    logic w_acc;

    assign w_acc = i_valid && o_ready;

    // radius update: step by the zoom step, saturate, clamp at the minimum radius
    logic [16:0] w_rsum;
    logic [15:0] w_rz;
    always_comb begin
        w_rsum = 17'(r_radius) + 17'(r_zoom_step);
        if (i_wheel_delta > 0)
            w_rz = (r_zoom_step > r_radius) ? 16'd0 : r_radius - r_zoom_step;
        else if (i_wheel_delta < 0)
            w_rz = w_rsum[16] ? 16'hFFFF : w_rsum[15:0];
        else
            w_rz = r_radius;
        n_radius = (w_rz < r_min_radius) ? r_min_radius : w_rz;
    end

    // angle steps: two 16x16 products, registered below
    logic signed [32:0] w_pdy, w_pdx;
    logic signed [24:0] w_sdy, w_sdx;
    logic signed [17:0] w_inc;
    assign w_pdy = r_dy * $signed({1'b0, r_turn_gain}) + 33'sd128;
    assign w_pdx = r_dx * $signed({1'b0, r_turn_gain}) + 33'sd128;
    assign w_sdy = 25'(w_pdy >>> 8);
    assign w_sdx = 25'(w_pdx >>> 8);
    always_comb begin
        n_incl = r_incl;
        n_azim = r_azim;
        w_inc = '0;
        if (r_held) begin
            if ((26'(w_sdy) + 26'(r_incl)) > 26'($signed({1'b0, r_max_incl})))
                w_inc = $signed({4'b0, r_max_incl});
            else if ((26'(w_sdy) + 26'(r_incl)) < -26'($signed({1'b0, r_max_incl})))
                w_inc = -$signed({4'b0, r_max_incl});
            else
                w_inc = 18'(26'(w_sdy) + 26'(r_incl));
            n_incl = w_inc[15:0];
            n_azim = r_azim + w_sdx[15:0];
        end
    end

    // sequencer next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            oce_pkg::ST_IDLE:   if (w_acc) n_state = oce_pkg::ST_ANGLE;
            oce_pkg::ST_ANGLE:  n_state = oce_pkg::ST_LOAD;
            oce_pkg::ST_LOAD:   n_state = oce_pkg::ST_CORDIC;
            oce_pkg::ST_CORDIC: if (r_iter == 5'(CORDIC_STEPS - 1)) n_state = oce_pkg::ST_MUL_GO;
            oce_pkg::ST_MUL_GO: n_state = oce_pkg::ST_MUL;
            oce_pkg::ST_MUL:    if (w_mdone) n_state = r_phase ? oce_pkg::ST_DONE
                                                               : oce_pkg::ST_MUL_GO;
            oce_pkg::ST_DONE:   if (!r_ovalid || i_ready) n_state = oce_pkg::ST_IDLE;
            default:            n_state = oce_pkg::ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        w_ctl.start = 1'b0;
        w_ctl.step = 1'b0;
        w_m_start = 1'b0;
        case (r_state)
            oce_pkg::ST_LOAD:   w_ctl.start = 1'b1;
            oce_pkg::ST_CORDIC: w_ctl.step = 1'b1;
            oce_pkg::ST_MUL_GO: w_m_start = 1'b1;
            default: ;
        endcase
    end

    assign o_ready = (r_state == oce_pkg::ST_IDLE);

    oce_cordic u_cordic (
        .i_clk(i_clk), .i_ctl(w_ctl), .i_iter(r_iter),
        .i_ang_a(r_incl), .i_ang_b(r_azim),
        .o_cos_a(w_ci), .o_sin_a(w_si), .o_cos_b(w_ca), .o_sin_b(w_sa)
    );

    // round 1: r*ci, r*si, r*si; round 2: (r*ci)*ca, r*si, (r*ci)*sa
    logic signed [33:0] r_rc, w_mul_a0, w_mul_a2;
    logic signed [17:0] w_mul_b0, w_mul_b2;
    logic signed [51:0] w_p0, w_p1, w_p2;
    logic w_d1, w_d2;
    logic signed [33:0] w_rad;
    assign w_rad = 34'($signed({1'b0, r_radius}));

    always_comb begin
        w_mul_a0 = r_phase ? r_rc : w_rad;
        w_mul_b0 = r_phase ? w_ca : w_ci;
        w_mul_a2 = r_phase ? r_rc : w_rad;
        w_mul_b2 = r_phase ? w_sa : w_si;
    end

    oce_serial_mul #(.AW(34), .BW(18)) u_mul0 (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_m_start), .i_a(w_mul_a0),
        .i_b(w_mul_b0), .o_done(w_mdone), .o_p(w_p0)
    );
    oce_serial_mul #(.AW(34), .BW(18)) u_mul1 (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_m_start), .i_a(w_rad),
        .i_b(w_si), .o_done(w_d1), .o_p(w_p1)
    );
    oce_serial_mul #(.AW(34), .BW(18)) u_mul2 (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_m_start), .i_a(w_mul_a2),
        .i_b(w_mul_b2), .o_done(w_d2), .o_p(w_p2)
    );

    function automatic logic signed [16:0] sat17(input logic signed [51:0] v);
        if (v > 52'sd65535) return 17'sd65535;
        if (v < -52'sd65535) return -17'sd65535;
        return v[16:0];
    endfunction

    logic signed [51:0] w_yr, w_xr, w_zr;
    assign w_yr = (w_p1 + 52'sh8000) >>> 16;
    assign w_xr = (w_p0 + 52'sh80000000) >>> 32;
    assign w_zr = (w_p2 + 52'sh80000000) >>> 32;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= oce_pkg::ST_IDLE;
            r_radius <= r_start_radius;
            r_incl <= 16'(r_start_incl);
            r_azim <= r_start_azim;
            r_iter <= '0;
            r_phase <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_acc) begin
                r_radius <= n_radius;
                r_dx <= i_pointer_dx;
                r_dy <= i_pointer_dy;
                r_held <= i_left_button;
            end
            if (r_state == oce_pkg::ST_ANGLE) begin
                r_incl <= n_incl;
                r_azim <= n_azim;
            end
            if (r_state == oce_pkg::ST_ANGLE) r_iter <= '0;
            else if (w_ctl.step) r_iter <= r_iter + 1'b1;
            // keep the first-round products, then run the second round
            if (r_state == oce_pkg::ST_MUL && w_mdone && !r_phase) begin
                r_phase <= 1'b1;
                r_rc <= w_p0[33:0];
                r_ey <= sat17(w_yr);
            end else if (r_state == oce_pkg::ST_IDLE) begin
                r_phase <= 1'b0;
            end
            // load the result once the output register is free
            if (r_state == oce_pkg::ST_DONE && (!r_ovalid || i_ready)) begin
                r_ovalid <= 1'b1;
                r_ex <= sat17(w_xr);
                r_ez <= sat17(w_zr);
                r_ey_q <= r_ey;
            end else if (r_ovalid && i_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    assign o_valid = r_ovalid;
    assign o_eye_x = r_ex;
    assign o_eye_y = r_ey_q;
    assign o_eye_z = r_ez;

    `OCE_ASSERT_IMP(a_ready_idle, i_clk, i_rst_n, o_ready, r_state == oce_pkg::ST_IDLE,
        "ready outside idle")
    `OCE_ASSERT_NXT(a_acc_angle, i_clk, i_rst_n, w_acc, r_state == oce_pkg::ST_ANGLE,
        "accept did not start work")
    `OCE_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid,
        "result dropped")
    `OCE_ASSERT_IMP(a_mul_lock, i_clk, i_rst_n, w_mdone, w_d1 && w_d2,
        "multipliers out of step")

endmodule
